[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PDIZ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pdiz assertion failed");

// Condition that must never be seen outside reset.
`define PDIZ_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("pdiz forbidden condition seen");

`endif

[hdl/pdiz_pkg.sv]
`timescale 1ns / 1ps

package pdiz_pkg;

  localparam int SCREEN_W = 512;
  localparam int SCREEN_H = 512;
  localparam int ADDR_W = $clog2(SCREEN_W * SCREEN_H);
  localparam int FRAC_BITS = 26;
  localparam int NORM_BITS = 44;
  localparam logic signed [31:0] DEPTH_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] DEPTH_MIN = 32'sh8000_0000;
  localparam logic [15:0] ATTR_MAX = 16'hffff;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_FRAG = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] SLOT_COUNT = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [1:0]         vert_slot;
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic signed [31:0] vert_depth;
    logic [15:0]        vert_u;
    logic [15:0]        vert_v;
    logic [8:0]         frag_x;
    logic [8:0]         frag_y;
  } item_t;

  typedef struct packed {
    logic               depth_pass;
    logic signed [31:0] frag_depth;
    logic [15:0]        frag_u;
    logic [15:0]        frag_v;
    logic               fault;
  } result_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [31:0] z;
    logic [15:0]        u;
    logic [15:0]        v;
  } vtx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_AREA_A,
    ST_AREA_B,
    ST_CHECK,
    ST_DIV_SETUP,
    ST_DIV_RUN,
    ST_DIV_DONE,
    ST_QSUM,
    ST_NORM,
    ST_MUL,
    ST_READ,
    ST_TEST,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    JOB_Q0,
    JOB_Q1,
    JOB_Q2,
    JOB_DEPTH,
    JOB_U,
    JOB_V
  } job_t;

endpackage

[hdl/perspective_depth_interp_zbuffer_top.sv]
`timescale 1ns / 1ps

// Channel  Direction  Signals                 Transfer
// item     in         start, busy, item       rising edge with start high and busy low
// result   out        done, result            every cycle in which done is high
//
// A load or an unknown command goes from ST_IDLE straight to ST_OUT; a clear
// does the same and then sweeps all SCREEN_W*SCREEN_H depth words. A fragment
// computes four areas, then runs up to 6 divisions on the shared 64-bit
// restoring divider (one quotient bit per cycle), normalising steps and 6
// multiply steps. After reset the depth buffer is swept with busy high.
// Results cannot be stalled.
module perspective_depth_interp_zbuffer_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pdiz_pkg::item_t  item,
  output logic             done,
  output pdiz_pkg::result_t result
);
  import pdiz_pkg::*;

  state_t state, state_next;
  job_t job;
  item_t cur;
  vtx_t vtx [3];
  logic [1:0] ai;
  logic [1:0] mi;
  logic [36:0] ta [4];
  logic signed [35:0] p1;
  logic signed [63:0] q [3];
  logic signed [63:0] qn [3];
  logic [63:0] mk;
  logic signed [31:0] dres;
  logic [15:0] ures, vres;
  logic signed [63:0] acc;
  logic [64:0] rem;
  logic [63:0] quo, dvs;
  logic dneg;
  logic [5:0] dcnt;
  logic [ADDR_W-1:0] clr_addr;
  logic clr_pending;
  logic signed [31:0] mem [SCREEN_W * SCREEN_H];
  logic signed [31:0] rd_data;
  result_t res;

  logic accept;
  logic signed [16:0] ax, ay, bx, by, cx, cy, px, py;
  logic signed [17:0] ex, ey, gx, gy;
  logic signed [35:0] prod_a, prod_b;
  logic signed [36:0] adiff;
  logic [36:0] aabs;
  logic signed [63:0] qs, qns, num, den, quot;
  logic [63:0] m0, m1, m2, mmax;
  logic [64:0] rem_sh, rem_sub;
  logic fault_c, in_screen;
  logic [ADDR_W-1:0] frag_addr;
  logic [15:0] attr;
  logic signed [16:0] attr_s;
  logic signed [61:0] mprod;
  logic signed [31:0] dsat;
  logic [15:0] aclamp;

  function automatic logic signed [63:0] half_trunc(input logic signed [63:0] a);
    logic signed [63:0] n;
    n = -a;
    return a[63] ? -(n >>> 1) : (a >>> 1);
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  assign accept = start && (state == ST_IDLE);
  assign px = $signed({4'b0, cur.frag_x, 4'b0});
  assign py = $signed({4'b0, cur.frag_y, 4'b0});

  always_comb begin
    ax = px; ay = py;
    bx = 17'(vtx[1].x); by = 17'(vtx[1].y);
    cx = 17'(vtx[2].x); cy = 17'(vtx[2].y);
    case (ai)
      2'd0: begin
        ax = 17'(vtx[0].x); ay = 17'(vtx[0].y);
      end
      2'd2: begin
        bx = 17'(vtx[0].x); by = 17'(vtx[0].y);
      end
      2'd3: begin
        cx = 17'(vtx[0].x); cy = 17'(vtx[0].y);
      end
      default: ;
    endcase
    ex = 18'(bx) - 18'(ax);
    ey = 18'(by) - 18'(ay);
    gx = 18'(cx) - 18'(ax);
    gy = 18'(cy) - 18'(ay);
    prod_a = ex * gy;
    prod_b = ey * gx;
    adiff = 37'(p1) - 37'(prod_b);
    aabs = adiff[36] ? 37'(-adiff) : 37'(adiff);
  end

  assign qs = q[0] + q[1] + q[2];
  assign qns = qn[0] + qn[1] + qn[2];
  assign m0 = mag(q[0]);
  assign m1 = mag(q[1]);
  assign m2 = mag(q[2]);
  always_comb begin
    mmax = m0;
    if (m1 > mmax) mmax = m1;
    if (m2 > mmax) mmax = m2;
  end

  assign fault_c = (ta[0] == '0) || (vtx[0].z == '0) || (vtx[1].z == '0) ||
                   (vtx[2].z == '0);
  assign in_screen = (int'(cur.frag_x) < SCREEN_W) && (int'(cur.frag_y) < SCREEN_H);
  assign frag_addr = ADDR_W'(int'(cur.frag_y) * SCREEN_W + int'(cur.frag_x));

  always_comb begin
    num = acc;
    den = qns;
    case (job)
      JOB_Q0: begin
        num = 64'(ta[1]) << FRAC_BITS; den = 64'(vtx[0].z);
      end
      JOB_Q1: begin
        num = 64'(ta[2]) << FRAC_BITS; den = 64'(vtx[1].z);
      end
      JOB_Q2: begin
        num = 64'(ta[3]) << FRAC_BITS; den = 64'(vtx[2].z);
      end
      JOB_DEPTH: begin
        num = 64'(ta[0]) << FRAC_BITS; den = qs;
      end
      default: ;
    endcase
  end

  assign rem_sh = {rem[63:0], quo[63]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign quot = dneg ? -$signed(quo) : $signed(quo);

  always_comb begin
    if (quot > 64'sd2147483647) dsat = DEPTH_MAX;
    else if (quot < -64'sd2147483648) dsat = DEPTH_MIN;
    else dsat = quot[31:0];
    if (quot < 0) aclamp = '0;
    else if (quot > 64'sd65535) aclamp = ATTR_MAX;
    else aclamp = quot[15:0];
  end

  assign attr = (job == JOB_V) ? vtx[mi].v : vtx[mi].u;
  assign attr_s = $signed({1'b0, attr});
  assign mprod = attr_s * $signed(qn[mi][44:0]);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = (item.cmd == CMD_FRAG) ? ST_AREA_A : ST_OUT;
      end
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(SCREEN_W * SCREEN_H - 1)) state_next = ST_IDLE;
      end
      ST_AREA_A: state_next = ST_AREA_B;
      ST_AREA_B: state_next = (ai == 2'd3) ? ST_CHECK : ST_AREA_A;
      ST_CHECK: state_next = fault_c ? ST_OUT : ST_DIV_SETUP;
      ST_DIV_SETUP: state_next = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (&dcnt) state_next = ST_DIV_DONE;
      end
      ST_DIV_DONE: begin
        unique case (job)
          JOB_Q0, JOB_Q1: state_next = ST_DIV_SETUP;
          JOB_Q2: state_next = ST_QSUM;
          JOB_DEPTH: state_next = ST_NORM;
          JOB_U: state_next = ST_MUL;
          default: state_next = ST_READ;
        endcase
      end
      ST_QSUM: state_next = (qs == '0) ? ST_NORM : ST_DIV_SETUP;
      ST_NORM: begin
        if (mk[63:NORM_BITS] == '0) state_next = (qns == '0) ? ST_READ : ST_MUL;
      end
      ST_MUL: begin
        if (mi == 2'd2) state_next = ST_DIV_SETUP;
      end
      ST_READ: state_next = ST_TEST;
      ST_TEST: state_next = ST_OUT;
      ST_OUT: state_next = clr_pending ? ST_CLEAR : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != ST_IDLE);
    done = (state == ST_OUT);
    result = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      clr_pending <= 1'b0;
      for (int i = 0; i < 3; i++) vtx[i] <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cur <= item;
            ai <= 2'd0;
            res <= '0;
            if (item.cmd == CMD_LOAD && item.vert_slot < SLOT_COUNT) begin
              vtx[item.vert_slot] <= '{item.vert_x, item.vert_y, item.vert_depth,
                                       item.vert_u, item.vert_v};
            end
            if (item.cmd == CMD_CLEAR) clr_pending <= 1'b1;
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (state_next == ST_IDLE) clr_pending <= 1'b0;
        end
        ST_AREA_A: p1 <= prod_a;
        ST_AREA_B: begin
          ta[ai] <= aabs;
          ai <= ai + 1'b1;
        end
        ST_CHECK: begin
          job <= JOB_Q0;
          if (fault_c) res.fault <= 1'b1;
        end
        ST_DIV_SETUP: begin
          rem <= '0;
          quo <= mag(num);
          dvs <= mag(den);
          dneg <= num[63] ^ den[63];
          dcnt <= '0;
        end
        ST_DIV_RUN: begin
          dcnt <= dcnt + 1'b1;
          if (!rem_sub[64]) begin
            rem <= rem_sub;
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[62:0], 1'b0};
          end
        end
        ST_DIV_DONE: begin
          unique case (job)
            JOB_Q0: begin
              q[0] <= quot; job <= JOB_Q1;
            end
            JOB_Q1: begin
              q[1] <= quot; job <= JOB_Q2;
            end
            JOB_Q2: q[2] <= quot;
            JOB_DEPTH: dres <= dsat;
            JOB_U: begin
              ures <= aclamp;
              acc <= '0;
              mi <= 2'd0;
              job <= JOB_V;
            end
            default: vres <= aclamp;
          endcase
        end
        ST_QSUM: begin
          for (int i = 0; i < 3; i++) qn[i] <= q[i];
          mk <= mmax;
          job <= JOB_DEPTH;
          if (qs == '0) dres <= DEPTH_MAX;
        end
        ST_NORM: begin
          if (mk[63:NORM_BITS] != '0) begin
            mk <= mk >> 1;
            for (int i = 0; i < 3; i++) qn[i] <= half_trunc(qn[i]);
          end else begin
            acc <= '0;
            mi <= 2'd0;
            job <= JOB_U;
            if (qns == '0) begin
              ures <= ATTR_MAX;
              vres <= ATTR_MAX;
            end
          end
        end
        ST_MUL: begin
          acc <= acc + 64'(mprod);
          mi <= mi + 1'b1;
        end
        ST_READ: ;
        ST_TEST: begin
          res.depth_pass <= in_screen && (dres < rd_data);
          res.frag_depth <= dres;
          res.frag_u <= ures;
          res.frag_v <= vres;
        end
        ST_OUT: clr_addr <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) rd_data <= mem[frag_addr];
    if (state == ST_CLEAR) begin
      mem[clr_addr] <= DEPTH_MAX;
    end else if (state == ST_TEST && in_screen && (dres < rd_data)) begin
      mem[frag_addr] <= dres;
    end
  end

endmodule

[hdl/pdiz_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pdiz_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input pdiz_pkg::result_t result
);
  import pdiz_pkg::*;

  `PDIZ_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy)
  `PDIZ_ASSERT(a_done_while_busy, clk, rst, done |-> busy)
  `PDIZ_ASSERT(a_done_single, clk, rst, done |=> !done)
  `PDIZ_NEVER(a_fault_no_pass, clk, rst, done && result.fault && result.depth_pass)

endmodule

bind perspective_depth_interp_zbuffer_top pdiz_checker u_pdiz_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .done(done), .result(result)
);
